// ----- rtl/bprf_pkg.sv -----
// Shared types, codes and helper function of the bit-plane rectangle engine.
package bprf_pkg;

	// Default store geometry.
	localparam int DEF_MAX_WIDTH  = 512;
	localparam int DEF_MAX_HEIGHT = 256;

	// Configuration register indexes.
	localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_SOURCE_PRESENT = 2'd2;

	// Action codes on the input channel.
	localparam logic [2:0] ACT_LOAD_SRC = 3'd0;
	localparam logic [2:0] ACT_READ     = 3'd1;
	localparam logic [2:0] ACT_CLEAR    = 3'd2;
	localparam logic [2:0] ACT_FILL     = 3'd3;
	localparam logic [2:0] ACT_COPY     = 3'd4;

	// Decoded operation class.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_READ,
		OP_CLEAR,
		OP_RECT
	} op_t;

	// Back end sequencer states.
	typedef enum logic [3:0] {
		BK_INIT,
		BK_IDLE,
		BK_START,
		BK_BYTE,
		BK_CLR,
		BK_MOD,
		BK_SETUP,
		BK_PRD,
		BK_PWR,
		BK_DONE
	} bk_state_t;

	// Effective frame geometry.
	typedef struct packed {
		logic [9:0]  w;
		logic [8:0]  h;
		logic [7:0]  rb;
		logic [15:0] nbytes;
	} geom_t;

	// Classified command handed from the front end to the back end.
	typedef struct packed {
		op_t         op;
		logic        copy;
		logic        addr_ok;
		logic [13:0] addr;
		logic [7:0]  bval;
		logic [9:0]  dx;
		logic [8:0]  dy;
		logic [9:0]  cols;
		logic [8:0]  rows;
		logic [15:0] sx;
		logic [15:0] sy;
		logic        fbit;
	} cmd_t;

	// One result item.
	typedef struct packed {
		logic [7:0]  read_data;
		logic [17:0] pixels_written;
	} res_t;

	// Length of a span starting at start, clipped at limit.
	function automatic logic [9:0] clip_len(logic [15:0] start, logic [15:0] len,
		logic [9:0] limit);
		logic [16:0] e;
		logic [9:0]  r;
		e = {1'b0, start} + {1'b0, len};
		if ({6'd0, limit} <= start) begin
			r = '0;
		end else if (e > {7'd0, limit}) begin
			r = limit - start[9:0];
		end else begin
			r = len[9:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/bitplane_rect_fill_copy.sv -----
// Top level of the one-bit-per-pixel rectangle fill and copy engine.
//
// Input items arrive through a queue-style port: an item transfers when push
// is high and full is low. Results leave through a second queue port: the
// oldest result sits on read_data and pixels_written while empty is low and
// transfers when pop is high. Every item gives exactly one result.
// The user writes configuration registers through cfg_write, cfg_index and
// cfg_data, only while the engine is idle; the engine does not enforce this.
// A front end decodes and clips each item into a two-entry command queue; the
// back end runs the frame and source stores, and results wait in a two-entry
// queue, so a stalled receiver holds the back end only once that queue fills.
// A clear writes the frame bytes in turn. A fill or copy first works out the
// source corner remainders in the serial remainder units, then does one store
// read and one store write per clipped pixel.
// After reset the frame store is cleared one byte a cycle, over every store
// byte (16384 with the default store size), and full stays high throughout.
module bitplane_rect_fill_copy #(
	parameter int MAX_WIDTH  = bprf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bprf_pkg::DEF_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  action,
	input  logic [13:0] byte_address,
	input  logic [7:0]  byte_value,
	input  logic [15:0] dest_x,
	input  logic [15:0] dest_y,
	input  logic [15:0] rect_width,
	input  logic [15:0] rect_height,
	input  logic [15:0] source_x,
	input  logic [15:0] source_y,
	input  logic        fill_bit,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  read_data,
	output logic [17:0] pixels_written
);
	import bprf_pkg::*;

	localparam int STORE = ((MAX_WIDTH + 7) / 8) * MAX_HEIGHT;

	logic [9:0] frame_width_q;
	logic [8:0] frame_height_q;
	logic       source_present_q;
	geom_t      geom;
	cmd_t       f_cmd;
	logic       f_valid;
	logic       q_full;
	cmd_t       b_cmd;
	logic       q_empty;
	logic       b_pop;
	logic       r_full;
	logic       r_push;
	res_t       r_in;
	res_t       r_out;
	logic       init_busy;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q    <= 10'd320;
			frame_height_q   <= 9'd256;
			source_present_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FRAME_WIDTH:    frame_width_q    <= cfg_data;
				REG_FRAME_HEIGHT:   frame_height_q   <= cfg_data[8:0];
				REG_SOURCE_PRESENT: source_present_q <= cfg_data[0];
				default:            frame_width_q    <= frame_width_q;
			endcase
		end
	end

	// Effective geometry, saturated to the store size.
	always_comb begin
		geom.w      = (32'(frame_width_q) > MAX_WIDTH) ? 10'(MAX_WIDTH) : frame_width_q;
		geom.h      = (32'(frame_height_q) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : frame_height_q;
		geom.rb     = 8'(({1'b0, geom.w} + 11'd7) >> 3);
		geom.nbytes = 16'(geom.rb) * 16'(geom.h);
	end

	bprf_front #(.STORE(STORE)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.hold         (init_busy),
		.action       (action),
		.byte_address (byte_address),
		.byte_value   (byte_value),
		.dest_x       (dest_x),
		.dest_y       (dest_y),
		.rect_width   (rect_width),
		.rect_height  (rect_height),
		.source_x     (source_x),
		.source_y     (source_y),
		.fill_bit     (fill_bit),
		.geom         (geom),
		.src_present  (source_present_q),
		.cmd          (f_cmd),
		.cmd_valid    (f_valid),
		.cmd_ready    (!q_full)
	);

	bprf_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(2)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_valid),
		.wdata  (f_cmd),
		.full   (q_full),
		.pop    (b_pop),
		.rdata  (b_cmd),
		.empty  (q_empty)
	);

	bprf_back #(.STORE(STORE)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.cmd       (b_cmd),
		.cmd_valid (!q_empty),
		.cmd_pop   (b_pop),
		.res_full  (r_full),
		.res_push  (r_push),
		.res       (r_in),
		.init_busy (init_busy)
	);

	bprf_fifo #(.WIDTH($bits(res_t)), .DEPTH(2)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (r_push),
		.wdata  (r_in),
		.full   (r_full),
		.pop    (pop),
		.rdata  (r_out),
		.empty  (empty)
	);

	assign read_data      = r_out.read_data;
	assign pixels_written = r_out.pixels_written;

endmodule

// ----- rtl/bprf_ram.sv -----
// Generic single write port RAM with one registered read port.
module bprf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/bprf_fifo.sv -----
// Small register queue used between the engine parts and on the result side.
module bprf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [PW:0]      cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == (PW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

// ----- rtl/bprf_front.sv -----
// Front end: accepts input items, decodes the action and clips rectangles.
module bprf_front #(
	parameter int STORE = 16384
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic                hold,
	input  logic [2:0]          action,
	input  logic [13:0]         byte_address,
	input  logic [7:0]          byte_value,
	input  logic [15:0]         dest_x,
	input  logic [15:0]         dest_y,
	input  logic [15:0]         rect_width,
	input  logic [15:0]         rect_height,
	input  logic [15:0]         source_x,
	input  logic [15:0]         source_y,
	input  logic                fill_bit,
	input  bprf_pkg::geom_t     geom,
	input  logic                src_present,
	output bprf_pkg::cmd_t      cmd,
	output logic                cmd_valid,
	input  logic                cmd_ready
);
	import bprf_pkg::*;

	cmd_t cmd_s1;
	logic vld_s1;
	cmd_t dec;
	logic accept;
	logic no_rect;

	assign full      = hold || (vld_s1 && !cmd_ready);
	assign accept    = push && !full;
	assign cmd       = cmd_s1;
	assign cmd_valid = vld_s1;

	// Classify the item and clip the rectangle to the frame.
	always_comb begin
		no_rect     = (action == ACT_COPY) && !src_present;
		dec.copy    = (action == ACT_COPY);
		dec.addr    = byte_address;
		dec.addr_ok = ({2'b00, byte_address} < geom.nbytes) &&
			(32'(byte_address) < STORE);
		dec.bval    = byte_value;
		dec.dx      = dest_x[9:0];
		dec.dy      = dest_y[8:0];
		dec.sx      = source_x;
		dec.sy      = source_y;
		dec.fbit    = fill_bit;
		dec.cols    = no_rect ? '0 : clip_len(dest_x, rect_width, geom.w);
		dec.rows    = no_rect ? '0 :
			9'(clip_len(dest_y, rect_height, {1'b0, geom.h}));
		case (action)
			ACT_LOAD_SRC: dec.op = OP_LOAD;
			ACT_READ:     dec.op = OP_READ;
			ACT_CLEAR:    dec.op = OP_CLEAR;
			ACT_FILL:     dec.op = OP_RECT;
			ACT_COPY:     dec.op = OP_RECT;
			default:      dec.op = OP_NONE;
		endcase
	end

	// Output stage towards the command queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept || (vld_s1 && !cmd_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= dec;
		end
	end

endmodule

// ----- rtl/bprf_mod.sv -----
// Bit-serial remainder unit: a 16-bit value modulo a 10-bit divisor.
module bprf_mod (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [9:0]  divisor,
	output logic        busy,
	output logic [9:0]  rem
);

	logic        busy_q;
	logic [3:0]  cnt_q;
	logic [15:0] num_q;
	logic [9:0]  div_q;
	logic [9:0]  rem_q;
	logic [10:0] trial;

	assign busy  = busy_q;
	assign rem   = rem_q;
	assign trial = {rem_q, num_q[15]};

	// Control: sixteen steps per remainder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == 4'hF) begin
				busy_q <= 1'b0;
			end
		end
	end

	// One restoring step per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[14:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_q <= 10'(trial - {1'b0, div_q});
			end else begin
				rem_q <= trial[9:0];
			end
		end
	end

endmodule

// ----- rtl/bprf_back.sv -----
// Back end: sequences the frame and source stores to carry out each command.
module bprf_back #(
	parameter int STORE = 16384
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bprf_pkg::geom_t  geom,
	input  bprf_pkg::cmd_t   cmd,
	input  logic             cmd_valid,
	output logic             cmd_pop,
	input  logic             res_full,
	output logic             res_push,
	output bprf_pkg::res_t   res,
	output logic             init_busy
);
	import bprf_pkg::*;

	localparam int AW = $clog2(STORE);

	bk_state_t   st_q;
	bk_state_t   st_nx;
	cmd_t        cur_q;
	logic [AW-1:0] cnt_q;
	logic [9:0]  i_q;
	logic [8:0]  j_q;
	logic [9:0]  x_q;
	logic [9:0]  px_q;
	logic [8:0]  py_q;
	logic [15:0] sxi_q;
	logic [15:0] syi_q;
	logic [15:0] dbase_q;
	logic [15:0] sbase_q;
	logic [7:0]  rdata_q;
	logic [17:0] count_q;

	logic [16:0] clr_lim;
	logic        clr_last;
	logic        init_last;
	logic        pix_last;
	logic        row_last;
	logic [15:0] daddr;
	logic [15:0] saddr;
	logic        mod_start;
	logic        xm_busy;
	logic        ym_busy;
	logic [9:0]  xrem;
	logic [9:0]  yrem;

	logic          f_we;
	logic [AW-1:0] f_waddr;
	logic [7:0]    f_wdata;
	logic [AW-1:0] f_raddr;
	logic [7:0]    f_rdata;
	logic          s_we;
	logic [7:0]    s_rdata;
	logic          pix;
	logic [7:0]    newbyte;

	// Store instances.
	bprf_ram #(.WIDTH(8), .DEPTH(STORE)) u_frame (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	bprf_ram #(.WIDTH(8), .DEPTH(STORE)) u_source (
		.clk   (clk),
		.we    (s_we),
		.waddr (AW'(cur_q.addr)),
		.wdata (cur_q.bval),
		.raddr (AW'(saddr)),
		.rdata (s_rdata)
	);

	// Start remainders of the source corner.
	bprf_mod u_xmod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (cur_q.sx),
		.divisor  (geom.w),
		.busy     (xm_busy),
		.rem      (xrem)
	);

	bprf_mod u_ymod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (cur_q.sy),
		.divisor  ({1'b0, geom.h}),
		.busy     (ym_busy),
		.rem      (yrem)
	);

	// Addresses, limits and loop ends.
	always_comb begin
		clr_lim   = (32'(geom.nbytes) < STORE) ? 17'(geom.nbytes) : 17'(STORE);
		clr_last  = (32'(cnt_q) + 32'd1 == 32'(clr_lim));
		init_last = (32'(cnt_q) == STORE - 1);
		pix_last  = (i_q == cur_q.cols - 10'd1);
		row_last  = (j_q == cur_q.rows - 9'd1);
		daddr     = dbase_q + 16'(x_q[9:3]);
		saddr     = sbase_q + 16'(px_q[9:3]);
		mod_start = (st_q == BK_START) && (cur_q.op == OP_RECT) &&
			(cur_q.cols != '0) && (cur_q.rows != '0);
		pix       = cur_q.copy ? s_rdata[~px_q[2:0]] : cur_q.fbit;
		newbyte   = f_rdata;
		newbyte[~x_q[2:0]] = pix;
	end

	// Next state.
	always_comb begin
		st_nx = st_q;
		case (st_q)
			BK_INIT: begin
				if (init_last) st_nx = BK_IDLE;
			end
			BK_IDLE: begin
				if (cmd_valid && !res_full) st_nx = BK_START;
			end
			BK_START: begin
				case (cur_q.op)
					OP_READ:  st_nx = BK_BYTE;
					OP_CLEAR: st_nx = (clr_lim == '0) ? BK_DONE : BK_CLR;
					OP_RECT:  st_nx = mod_start ? BK_MOD : BK_DONE;
					default:  st_nx = BK_DONE;
				endcase
			end
			BK_BYTE: st_nx = BK_DONE;
			BK_CLR: begin
				if (clr_last) st_nx = BK_DONE;
			end
			BK_MOD: begin
				if (!xm_busy && !ym_busy) st_nx = BK_SETUP;
			end
			BK_SETUP: st_nx = BK_PRD;
			BK_PRD:   st_nx = BK_PWR;
			BK_PWR:   st_nx = (pix_last && row_last) ? BK_DONE : BK_PRD;
			BK_DONE:  st_nx = BK_IDLE;
			default:  st_nx = BK_IDLE;
		endcase
	end

	// Store controls and handshakes.
	always_comb begin
		f_we      = 1'b0;
		f_waddr   = cnt_q;
		f_wdata   = '0;
		s_we      = (st_q == BK_START) && (cur_q.op == OP_LOAD) && cur_q.addr_ok;
		f_raddr   = (st_q == BK_START) ? AW'(cur_q.addr) : AW'(daddr);
		cmd_pop   = (st_q == BK_IDLE) && cmd_valid && !res_full;
		res_push  = (st_q == BK_DONE);
		init_busy = (st_q == BK_INIT);
		res.read_data      = rdata_q;
		res.pixels_written = count_q;
		case (st_q)
			BK_INIT: begin
				f_we = 1'b1;
			end
			BK_CLR: begin
				f_we    = 1'b1;
				f_wdata = cur_q.bval;
			end
			BK_PWR: begin
				f_we    = 1'b1;
				f_waddr = AW'(daddr);
				f_wdata = newbyte;
			end
			default: begin
				f_we = 1'b0;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= BK_INIT;
			cnt_q <= '0;
		end else begin
			st_q <= st_nx;
			if (st_q == BK_START) begin
				cnt_q <= '0;
			end else if (st_q == BK_INIT || st_q == BK_CLR) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
		end
		case (st_q)
			BK_START: begin
				rdata_q <= '0;
				count_q <= (cur_q.op == OP_CLEAR) ? 18'(geom.w) * 18'(geom.h) : '0;
			end
			BK_BYTE: begin
				rdata_q <= cur_q.addr_ok ? f_rdata : '0;
			end
			BK_SETUP: begin
				dbase_q <= 16'(cur_q.dy) * 16'(geom.rb);
				sbase_q <= 16'(yrem[8:0]) * 16'(geom.rb);
				px_q    <= xrem;
				py_q    <= yrem[8:0];
				sxi_q   <= cur_q.sx;
				syi_q   <= cur_q.sy;
				i_q     <= '0;
				j_q     <= '0;
				x_q     <= cur_q.dx;
				count_q <= 18'(cur_q.cols) * 18'(cur_q.rows);
			end
			BK_PWR: begin
				if (pix_last) begin
					// Next row: rewind the columns and step both row bases.
					i_q     <= '0;
					x_q     <= cur_q.dx;
					px_q    <= xrem;
					sxi_q   <= cur_q.sx;
					j_q     <= j_q + 1'b1;
					dbase_q <= dbase_q + 16'(geom.rb);
					syi_q   <= syi_q + 1'b1;
					if (syi_q == 16'hFFFF || py_q == geom.h - 9'd1) begin
						py_q    <= '0;
						sbase_q <= '0;
					end else begin
						py_q    <= py_q + 1'b1;
						sbase_q <= sbase_q + 16'(geom.rb);
					end
				end else begin
					i_q   <= i_q + 1'b1;
					x_q   <= x_q + 1'b1;
					sxi_q <= sxi_q + 1'b1;
					if (sxi_q == 16'hFFFF || px_q == geom.w - 10'd1) begin
						px_q <= '0;
					end else begin
						px_q <= px_q + 1'b1;
					end
				end
			end
			default: begin
				rdata_q <= rdata_q;
			end
		endcase
	end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the bit-plane rectangle fill and copy engine.
module tb_top;
	import bprf_pkg::*;

	// One input item as it is presented on the push side.
	typedef struct {
		logic [2:0]  action;
		logic [13:0] byte_address;
		logic [7:0]  byte_value;
		logic [15:0] dest_x;
		logic [15:0] dest_y;
		logic [15:0] rect_width;
		logic [15:0] rect_height;
		logic [15:0] source_x;
		logic [15:0] source_y;
		logic        fill_bit;
	} item_t;

	// Tracks both planes and the geometry, and predicts each result.
	class plane_predictor;
		logic [7:0]  frame_bytes [16384];
		logic [7:0]  source_bytes [16384];
		int unsigned width_reg = 320;
		int unsigned height_reg = 256;
		bit          source_on = 0;
		res_t        expected_results [$];
		int          errors = 0;

		function new();
			foreach (frame_bytes[k]) begin
				frame_bytes[k] = 8'h00;
				source_bytes[k] = 8'h00;
			end
		endfunction

		function void set_register(logic [1:0] idx, logic [9:0] value);
			case (idx)
				REG_FRAME_WIDTH: width_reg = 32'(value);
				REG_FRAME_HEIGHT: height_reg = 32'(value[8:0]);
				REG_SOURCE_PRESENT: source_on = value[0];
				default: ;
			endcase
		endfunction

		function int unsigned span(int unsigned start, int unsigned len, int unsigned limit);
			if (start >= limit)
				return 0;
			return (start + len > limit) ? limit - start : len;
		endfunction

		// Apply one transferred item to the planes and queue its result.
		function void note_item(item_t it);
			int unsigned w, h, rb, nb, cols, rows, px, py, idx;
			logic        pix;
			res_t        r;
			w = (width_reg > 512) ? 512 : width_reg;
			h = (height_reg > 256) ? 256 : height_reg;
			rb = (w + 7) / 8;
			nb = rb * h;
			r = '0;
			case (it.action)
				ACT_LOAD_SRC: if (it.byte_address < nb) source_bytes[it.byte_address] = it.byte_value;
				ACT_READ: if (it.byte_address < nb) r.read_data = frame_bytes[it.byte_address];
				ACT_CLEAR: begin
					for (int k = 0; k < nb; k++)
						frame_bytes[k] = it.byte_value;
					r.pixels_written = 18'(w * h);
				end
				ACT_FILL, ACT_COPY: begin
					if (it.action == ACT_COPY && !source_on) begin
						cols = 0;
						rows = 0;
					end else begin
						cols = span(32'(it.dest_x), 32'(it.rect_width), w);
						rows = span(32'(it.dest_y), 32'(it.rect_height), h);
					end
					for (int j = 0; j < rows; j++) begin
						for (int i = 0; i < cols; i++) begin
							pix = it.fill_bit;
							if (it.action == ACT_COPY) begin
								px = ((it.source_x + i) & 16'hFFFF) % w;
								py = ((it.source_y + j) & 16'hFFFF) % h;
								pix = source_bytes[py * rb + px / 8][7 - px % 8];
							end
							idx = (it.dest_y + j) * rb + (it.dest_x + i) / 8;
							frame_bytes[idx][7 - (it.dest_x + i) % 8] = pix;
						end
					end
					r.pixels_written = 18'(rows * cols);
				end
				default: ;
			endcase
			expected_results.push_back(r);
		endfunction

		// Compare one transferred result with the oldest expectation.
		function void check_result(logic [7:0] rd, logic [17:0] pw);
			res_t e;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result read_data=%0h pixels_written=%0d", $time, rd, pw);
				errors++;
				return;
			end
			e = expected_results.pop_front();
			if (rd !== e.read_data) begin
				$display("%0t: read_data expected %0h actual %0h", $time, e.read_data, rd);
				errors++;
			end
			if (pw !== e.pixels_written) begin
				$display("%0t: pixels_written expected %0d actual %0d", $time,
					e.pixels_written, pw);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_write = 0;
	logic [1:0]  cfg_index = '0;
	logic [9:0]  cfg_data = '0;
	logic        push = 0;
	logic        full;
	logic [2:0]  action = '0;
	logic [13:0] byte_address = '0;
	logic [7:0]  byte_value = '0;
	logic [15:0] dest_x = '0;
	logic [15:0] dest_y = '0;
	logic [15:0] rect_width = '0;
	logic [15:0] rect_height = '0;
	logic [15:0] source_x = '0;
	logic [15:0] source_y = '0;
	logic        fill_bit = 0;
	logic        empty;
	logic        pop = 0;
	logic [7:0]  read_data;
	logic [17:0] pixels_written;

	plane_predictor planes = new();
	bit calm = 0;
	bit hold_pop = 0;

	bitplane_rect_fill_copy dut (.*);

	always #5 clk = ~clk;

	// Present one item and hold it until it transfers.
	task automatic send_item(item_t it);
		while (!calm && $urandom_range(0, 99) < 8) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		action <= it.action;
		byte_address <= it.byte_address;
		byte_value <= it.byte_value;
		dest_x <= it.dest_x;
		dest_y <= it.dest_y;
		rect_width <= it.rect_width;
		rect_height <= it.rect_height;
		source_x <= it.source_x;
		source_y <= it.source_y;
		fill_bit <= it.fill_bit;
		do
			@(posedge clk);
		while (full);
		planes.note_item(it);
	endtask

	// Stop offering items and wait until every result has arrived.
	task automatic drain();
		push <= 1'b0;
		while (planes.expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [9:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		planes.set_register(idx, value);
	endtask

	function automatic item_t blank_item(logic [2:0] act);
		item_t it;
		it.action = act;
		it.byte_address = 14'($urandom());
		it.byte_value = 8'($urandom());
		it.dest_x = 16'($urandom());
		it.dest_y = 16'($urandom());
		it.rect_width = 16'($urandom());
		it.rect_height = 16'($urandom());
		it.source_x = 16'($urandom());
		it.source_y = 16'($urandom());
		it.fill_bit = 1'($urandom());
		return it;
	endfunction

	function automatic item_t rect_item(logic [2:0] act, int x, int y, int rw, int rh, bit b);
		item_t it;
		it = blank_item(act);
		it.dest_x = 16'(x);
		it.dest_y = 16'(y);
		it.rect_width = 16'(rw);
		it.rect_height = 16'(rh);
		it.fill_bit = b;
		return it;
	endfunction

	function automatic item_t byte_item(logic [2:0] act, int addr, int value);
		item_t it;
		it = blank_item(act);
		it.byte_address = 14'(addr);
		it.byte_value = 8'(value);
		return it;
	endfunction

	// Random item shaped for a frame of w by h pixels.
	function automatic item_t random_item(int unsigned w, int unsigned h, int unsigned nb);
		item_t       it;
		int unsigned pick, shape;
		bit          wide;
		wide = (w * h > 4096);
		pick = $urandom_range(0, 99);
		if (pick < 20)
			it = blank_item(ACT_LOAD_SRC);
		else if (pick < 40)
			it = blank_item(ACT_READ);
		else if (pick < 45)
			it = blank_item(ACT_CLEAR);
		else if (pick < 70)
			it = blank_item(ACT_FILL);
		else if (pick < 95)
			it = blank_item(ACT_COPY);
		else
			it = blank_item(3'(ACT_COPY + $urandom_range(1, 3)));
		if (nb > 0 && $urandom_range(0, 9) < 8)
			it.byte_address = 14'($urandom_range(0, nb - 1));
		if ($urandom_range(0, 9) < 8) begin
			it.dest_x = 16'($urandom_range(0, w));
			it.dest_y = 16'($urandom_range(0, h));
		end
		// Keep pixel counts bounded so large frames stay quick.
		shape = $urandom_range(0, 9);
		if (shape == 0) begin
			it.rect_height = 16'(wide ? $urandom_range(0, 2) : $urandom_range(0, h + 2));
		end else if (shape == 1) begin
			it.rect_width = 16'(wide ? $urandom_range(0, 4) : $urandom_range(0, w + 2));
		end else begin
			it.rect_width = 16'(wide ? $urandom_range(0, 64) : $urandom_range(0, w + 2));
			it.rect_height = 16'(wide ? $urandom_range(0, 8) : $urandom_range(0, h + 2));
		end
		return it;
	endfunction

	// Result side: check each transfer, stall at random, and once hold off long.
	initial begin
		forever begin
			@(posedge clk);
			if (pop && !empty)
				planes.check_result(read_data, pixels_written);
			if (hold_pop) begin
				hold_pop = 0;
				pop <= 1'b0;
				repeat (300) @(posedge clk);
			end
			pop <= calm || ($urandom_range(0, 99) >= 8);
		end
	end

	initial begin
		#200000000;
		$display("end of test: mismatches");
		$finish;
	end

	// Stimulus: directed items at the reset geometry, then random phases.
	initial begin
		int unsigned widths [10] = '{1, 512, 1023, 0, 9, 64, 0, 0, 0, 0};
		int unsigned heights [10] = '{1, 256, 511, 0, 3, 4, 0, 0, 0, 0};
		bit          sources [10] = '{1, 0, 0, 1, 1, 1, 0, 0, 0, 0};
		int unsigned w, h, nb;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		do
			@(posedge clk);
		while (full);

		send_item(byte_item(ACT_READ, 0, 0));
		send_item(byte_item(ACT_CLEAR, 0, 8'hFF));
		send_item(byte_item(ACT_READ, 10239, 0));
		send_item(byte_item(ACT_READ, 10240, 0));
		send_item(byte_item(ACT_READ, 16383, 0));
		send_item(byte_item(ACT_LOAD_SRC, 0, 8'h5A));
		send_item(byte_item(ACT_LOAD_SRC, 16383, 8'hA5));
		send_item(rect_item(ACT_FILL, 0, 0, 8, 1, 0));
		send_item(byte_item(ACT_READ, 0, 0));
		// Rectangle clipped at both the right and bottom edges.
		send_item(rect_item(ACT_FILL, 310, 250, 65535, 65535, 0));
		send_item(byte_item(ACT_READ, 10239, 0));
		send_item(rect_item(ACT_FILL, 65535, 0, 5, 5, 0));
		send_item(rect_item(ACT_FILL, 0, 65535, 5, 5, 0));
		send_item(rect_item(ACT_FILL, 4, 4, 0, 3, 0));
		send_item(rect_item(ACT_FILL, 3, 1, 1, 1, 0));
		send_item(byte_item(ACT_READ, 40, 0));
		// Copy with no source plane writes nothing.
		send_item(rect_item(ACT_COPY, 0, 0, 8, 1, 0));
		send_item(blank_item(3'(ACT_COPY + 1)));
		send_item(blank_item(3'(ACT_COPY + 2)));
		send_item(blank_item(3'(ACT_COPY + 3)));
		send_item(byte_item(ACT_CLEAR, 0, 8'h00));
		send_item(byte_item(ACT_READ, 100, 0));
		drain();

		for (int p = 0; p < 10; p++) begin
			if (p >= 6) begin
				widths[p] = $urandom_range(1, 72);
				heights[p] = $urandom_range(1, 24);
				sources[p] = 1'($urandom());
			end
			w = (widths[p] > 512) ? 512 : widths[p];
			h = (heights[p] > 256) ? 256 : heights[p];
			nb = ((w + 7) / 8) * h;
			if (nb > 256)
				sources[p] = 0;
			write_reg(REG_FRAME_WIDTH, 10'(widths[p]));
			write_reg(REG_FRAME_HEIGHT, 10'(heights[p]));
			write_reg(REG_SOURCE_PRESENT, 10'(sources[p]));
			cfg_write <= 1'b0;
			@(posedge clk);
			calm = (p == 7);
			// Fill the whole source plane so that a copy never reads unwritten bytes.
			if (sources[p])
				for (int k = 0; k < nb; k++)
					send_item(byte_item(ACT_LOAD_SRC, k, int'($urandom_range(0, 255))));
			if (p == 6)
				hold_pop = 1;
			repeat (90)
				send_item(random_item(w, h, nb));
			drain();
		end

		if (planes.errors == 0 && planes.expected_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/bprf_pkg.sv
rtl/bprf_ram.sv
rtl/bprf_fifo.sv
rtl/bprf_front.sv
rtl/bprf_mod.sv
rtl/bprf_back.sv
rtl/bitplane_rect_fill_copy.sv
tb/tb_top.sv
